// ===== hdl/pcsd_pkg.sv =====
// Shared types and constants of the pixel-control stream deframer.
// Used by the parser and the top level; depends on nothing.
`timescale 1ns / 1ps

package pcsd_pkg;

	localparam int MAX_SIDE = 1024;
	localparam int CFG_W    = 11;
	localparam int SIDE_W   = 11;
	localparam int COORD_W  = 10;
	localparam int LEN_W    = 16;

	localparam logic [SIDE_W-1:0] SIDE_LIMIT = SIDE_W'(MAX_SIDE);
	localparam logic [CFG_W-1:0]  SIDE_RESET = CFG_W'(16);

	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t CFG_IDX_WIDTH  = 1'b0;
	localparam cfg_idx_t CFG_IDX_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		HDR_CHANNEL,
		HDR_COMMAND,
		HDR_LEN_HI,
		HDR_LEN_LO
	} hdr_idx_t;

	typedef enum logic [1:0] {
		COMP_RED,
		COMP_GREEN,
		COMP_BLUE,
		COMP_NONE
	} comp_t;

	typedef struct packed {
		logic               pixel_write;
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
		logic [1:0]         component;
		logic [7:0]         byte_value;
		logic               frame_end;
	} pcsd_result_t;

	function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
		clamp_side = (v > CFG_W'(MAX_SIDE)) ? SIDE_LIMIT : SIDE_W'(v);
	endfunction

endpackage

// ===== hdl/pcsd_parser.sv =====
// Header parser and payload walker: one stream word in, at most one result out.
// Depends on pcsd_pkg.
`timescale 1ns / 1ps

module pcsd_parser (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [7:0]                   data_byte,
	input  logic [pcsd_pkg::SIDE_W-1:0]  side_w,
	input  logic [pcsd_pkg::SIDE_W-1:0]  side_h,
	output logic                         res_valid,
	output pcsd_pkg::pcsd_result_t       res
);
	import pcsd_pkg::*;

	logic                 in_header_q, in_header_d;
	hdr_idx_t             hdr_idx_q, hdr_idx_d;
	logic                 channel_ok_q, channel_ok_d;
	logic                 command_ok_q, command_ok_d;
	logic [7:0]           length_high_q, length_high_d;
	logic [LEN_W-1:0]     remaining_q, remaining_d;
	logic                 accepted_q, accepted_d;
	comp_t                comp_q, comp_d;
	logic [SIDE_W-1:0]    col_q, col_d;
	logic [COORD_W-1:0]   row_q, row_d;

	logic [LEN_W-1:0]     frame_len;
	logic [SIDE_W-1:0]    row_ext;
	logic [SIDE_W-1:0]    row_next;
	logic [SIDE_W-1:0]    row_rev;
	logic                 in_matrix;

	assign frame_len = {length_high_q, data_byte};
	assign row_ext   = SIDE_W'(row_q);
	assign row_next  = row_ext + SIDE_W'(1);
	assign row_rev   = side_h - SIDE_W'(1) - row_ext;
	assign in_matrix = accepted_q && (col_q < side_w) && (row_ext < side_h);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_header_q   <= 1'b1;
			hdr_idx_q     <= HDR_CHANNEL;
			channel_ok_q  <= 1'b1;
			command_ok_q  <= 1'b1;
			length_high_q <= '0;
			remaining_q   <= '0;
			accepted_q    <= 1'b0;
			comp_q        <= COMP_RED;
			col_q         <= '0;
			row_q         <= '0;
		end else begin
			in_header_q   <= in_header_d;
			hdr_idx_q     <= hdr_idx_d;
			channel_ok_q  <= channel_ok_d;
			command_ok_q  <= command_ok_d;
			length_high_q <= length_high_d;
			remaining_q   <= remaining_d;
			accepted_q    <= accepted_d;
			comp_q        <= comp_d;
			col_q         <= col_d;
			row_q         <= row_d;
		end
	end

	always_comb begin
		in_header_d   = in_header_q;
		hdr_idx_d     = hdr_idx_q;
		channel_ok_d  = channel_ok_q;
		command_ok_d  = command_ok_q;
		length_high_d = length_high_q;
		remaining_d   = remaining_q;
		accepted_d    = accepted_q;
		comp_d        = comp_q;
		col_d         = col_q;
		row_d         = row_q;
		res           = '0;
		res_valid     = 1'b0;

		if (step) begin
			if (in_header_q) begin
				case (hdr_idx_q)
					HDR_CHANNEL: begin
						channel_ok_d = (data_byte <= 8'd1);
						hdr_idx_d    = HDR_COMMAND;
					end
					HDR_COMMAND: begin
						command_ok_d = (data_byte == 8'd0);
						hdr_idx_d    = HDR_LEN_HI;
					end
					HDR_LEN_HI: begin
						length_high_d = data_byte;
						hdr_idx_d     = HDR_LEN_LO;
					end
					HDR_LEN_LO: begin
						hdr_idx_d   = HDR_CHANNEL;
						accepted_d  = channel_ok_q && command_ok_q;
						remaining_d = frame_len;
						comp_d      = COMP_RED;
						col_d       = '0;
						row_d       = '0;
						if (frame_len == '0) begin
							res_valid     = 1'b1;
							res.frame_end = 1'b1;
						end else begin
							in_header_d = 1'b0;
						end
					end
					default: ;
				endcase
			end else begin
				if (in_matrix) begin
					res.pixel_write = 1'b1;
					res.column      = col_q[COORD_W-1:0];
					res.row         = col_q[0] ? row_q : row_rev[COORD_W-1:0];
					res.component   = comp_q;
					res.byte_value  = data_byte;
				end

				// advance to the next component, row, column
				if (comp_q == COMP_BLUE || comp_q == COMP_NONE) begin
					comp_d = COMP_RED;
					if (row_next >= side_h) begin
						row_d = '0;
						if (col_q < SIDE_LIMIT)
							col_d = col_q + SIDE_W'(1);
					end else begin
						row_d = row_next[COORD_W-1:0];
					end
				end else begin
					comp_d = comp_t'(comp_q + 2'd1);
				end

				remaining_d = remaining_q - LEN_W'(1);
				if (remaining_q == LEN_W'(1)) begin
					res.frame_end = 1'b1;
					in_header_d   = 1'b1;
					hdr_idx_d     = HDR_CHANNEL;
				end
				res_valid = res.pixel_write || res.frame_end;
			end
		end
	end

endmodule

// ===== hdl/pixel_control_stream_deframer_core.sv =====
// Top level of the pixel-control stream deframer: ports, size registers,
// two-entry result buffer. Depends on pcsd_pkg and pcsd_parser.
`timescale 1ns / 1ps

// Takes one stream word per clock cycle while in_ready is high, with no gaps
// needed between words. A result, when a word causes one, goes to the output
// register, or to the skid register while the output holds. Results pass
// through a two-entry buffer (output register plus skid register), so in_ready
// stays high while one result waits and drops only when both entries are full.
// The size registers are written on the cfg channel, which is always ready;
// write them only while no frame is in flight. Sizes above 1024 act as 1024.
module pixel_control_stream_deframer_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  pcsd_pkg::cfg_idx_t              cfg_index,
	input  logic [pcsd_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      data_byte,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            pixel_write,
	output logic [pcsd_pkg::COORD_W-1:0]    column,
	output logic [pcsd_pkg::COORD_W-1:0]    row,
	output logic [1:0]                      component,
	output logic [7:0]                      byte_value,
	output logic                            frame_end
);
	import pcsd_pkg::*;

	logic [CFG_W-1:0]  width_q, height_q;
	logic              step;
	logic              res_valid;
	pcsd_result_t      res;
	pcsd_result_t      out_q, skid_q;
	logic              out_valid_q, skid_valid_q;
	logic              pop;
	logic              push;

	assign cfg_ready = 1'b1;
	assign in_ready  = !skid_valid_q;
	assign step      = in_valid && in_ready;
	assign push      = step && res_valid;
	assign pop       = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIDE_RESET;
			height_q <= SIDE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_IDX_WIDTH:  width_q  <= cfg_data;
				CFG_IDX_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	pcsd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (data_byte),
		.side_w    (clamp_side(width_q)),
		.side_h    (clamp_side(height_q)),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= skid_valid_q && push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload refills from skid first, parks a new result in skid when output holds
	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_q  <= skid_q;
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_write = out_q.pixel_write;
	assign column      = out_q.column;
	assign row         = out_q.row;
	assign component   = out_q.component;
	assign byte_value  = out_q.byte_value;
	assign frame_end   = out_q.frame_end;

endmodule

// ===== hdl/pcsd_checker.sv =====
// Port-level checks of the pixel-control stream deframer, bound to the top.
// Depends on pixel_control_stream_deframer_core.
`timescale 1ns / 1ps

module pcsd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       pixel_write,
	input logic [9:0] column,
	input logic [9:0] row,
	input logic [1:0] component,
	input logic [7:0] byte_value,
	input logic       frame_end
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pixel_write || frame_end)
		else $error("result carries neither write nor frame end");

	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pixel_write |->
			column == 10'd0 && row == 10'd0 && component == 2'd0 && byte_value == 8'd0)
		else $error("fields set on a result without write");

	a_component: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pixel_write |-> component != 2'd3)
		else $error("component code out of range");

endmodule

bind pixel_control_stream_deframer_core pcsd_checker u_pcsd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.pixel_write (pixel_write),
	.column      (column),
	.row         (row),
	.component   (component),
	.byte_value  (byte_value),
	.frame_end   (frame_end)
);
